### hw/rtl/csl_pkg.sv
// Token kinds, lexer modes, character classes and keyword tables for the lexer.
`default_nettype none

package csl_pkg;

  typedef enum logic [5:0] {
    TK_EOF      = 6'd0,
    TK_INT_LIT  = 6'd1,
    TK_IDENT    = 6'd2,
    TK_KW_INT   = 6'd3,
    TK_KW_CHAR  = 6'd4,
    TK_KW_IF    = 6'd5,
    TK_KW_ELSE  = 6'd6,
    TK_KW_FOR   = 6'd7,
    TK_KW_WHILE = 6'd8,
    TK_KW_TRUE  = 6'd9,
    TK_KW_FALSE = 6'd10,
    TK_STRING   = 6'd11,
    TK_PLUS     = 6'd12,
    TK_MINUS    = 6'd13,
    TK_STAR     = 6'd14,
    TK_SLASH    = 6'd15,
    TK_GT       = 6'd16,
    TK_GE       = 6'd17,
    TK_LT       = 6'd18,
    TK_LE       = 6'd19,
    TK_ASSIGN   = 6'd20,
    TK_EQ       = 6'd21,
    TK_AMP      = 6'd22,
    TK_ANDAND   = 6'd23,
    TK_PIPE     = 6'd24,
    TK_OROR     = 6'd25,
    TK_BANG     = 6'd26,
    TK_NE       = 6'd27,
    TK_LPAREN   = 6'd28,
    TK_RPAREN   = 6'd29,
    TK_LBRACK   = 6'd30,
    TK_RBRACK   = 6'd31,
    TK_LBRACE   = 6'd32,
    TK_RBRACE   = 6'd33,
    TK_COMMA    = 6'd34,
    TK_SEMI     = 6'd35,
    TK_BAD_CHAR = 6'd36,
    TK_UNCLOSED = 6'd37
  } kind_e;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_NUM    = 4'd1,
    M_IDENT  = 4'd2,
    M_STR    = 4'd3,
    M_ESC    = 4'd4,
    M_OP_GT  = 4'd5,
    M_OP_LT  = 4'd6,
    M_OP_EQ  = 4'd7,
    M_OP_AND = 4'd8,
    M_OP_OR  = 4'd9,
    M_OP_NOT = 4'd10
  } mode_e;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int NUM_KW = 8;

  // int char if else for while true false
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5};

  localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
    '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00},
    '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65}
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR};
  endfunction

  // Single-character tokens; TK_BAD_CHAR means the byte is not one of them.
  function automatic kind_e single_kind(input logic [7:0] c);
    kind_e k;
    case (c)
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_STAR;
      8'h2F:   k = TK_SLASH;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h5B:   k = TK_LBRACK;
      8'h5D:   k = TK_RBRACK;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h2C:   k = TK_COMMA;
      8'h3B:   k = TK_SEMI;
      default: k = TK_BAD_CHAR;
    endcase
    return k;
  endfunction

  // Lead byte of a possible two-character operator; M_IDLE if none.
  function automatic mode_e op_mode(input logic [7:0] c);
    mode_e m;
    case (c)
      8'h3E:   m = M_OP_GT;
      8'h3C:   m = M_OP_LT;
      8'h3D:   m = M_OP_EQ;
      8'h26:   m = M_OP_AND;
      8'h7C:   m = M_OP_OR;
      8'h21:   m = M_OP_NOT;
      default: m = M_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] op_second(input mode_e m);
    logic [7:0] c;
    case (m)
      M_OP_AND: c = 8'h26;
      M_OP_OR:  c = 8'h7C;
      default:  c = 8'h3D;
    endcase
    return c;
  endfunction

  function automatic kind_e op_single(input mode_e m);
    kind_e k;
    case (m)
      M_OP_GT:  k = TK_GT;
      M_OP_LT:  k = TK_LT;
      M_OP_EQ:  k = TK_ASSIGN;
      M_OP_AND: k = TK_AMP;
      M_OP_OR:  k = TK_PIPE;
      default:  k = TK_BANG;
    endcase
    return k;
  endfunction

  function automatic kind_e op_pair(input mode_e m);
    kind_e k;
    case (m)
      M_OP_GT:  k = TK_GE;
      M_OP_LT:  k = TK_LE;
      M_OP_EQ:  k = TK_EQ;
      M_OP_AND: k = TK_ANDAND;
      M_OP_OR:  k = TK_OROR;
      default:  k = TK_NE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/c_subset_lexer.sv
// Top level of the streaming C-subset lexer: lexer core plus a four-entry token queue.
//
// Bytes go in on the request channel, one per cycle, with is_end_i closing the stream; tokens
// come out with kind, start line, start column, length and the offending byte for a bad
// character. A token enters the output queue when the byte that completes it is accepted.
// The lexer core does all per-byte work in one pass, so a byte that yields zero or one token
// is taken every cycle as long as no more than one token is waiting in the output queue.
// A byte that yields two or three tokens (a cut-off string, the end of the stream) holds
// in_ready_o low while the queue drains at one token per cycle as long as out_ready_i is high.
// last_of_run_o marks the last token caused by a byte. There is no start-up pass after reset.
`default_nettype none

module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               char_code_i,
  input  wire logic                     is_end_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [5:0]               token_kind_o,
  output logic      [POSITION_BITS-1:0] token_line_o,
  output logic      [POSITION_BITS-1:0] token_column_o,
  output logic      [7:0]               token_length_o,
  output logic      [7:0]               bad_char_o,
  output logic                          last_of_run_o
);

  localparam int PW    = POSITION_BITS;
  localparam int DEPTH = 4;

  logic            accept, pop;
  logic [1:0]      res_n;
  logic [5:0]      res_kind   [3];
  logic [PW-1:0]   res_line   [3];
  logic [PW-1:0]   res_column [3];
  logic [7:0]      res_length [3];
  logic [7:0]      res_bad    [3];

  logic [2:0]      cnt_q, cnt_d, cnt_kept;
  logic [1:0]      push_n;
  logic [5:0]      ent_kind_q [DEPTH], ent_kind_d [DEPTH];
  logic [PW-1:0]   ent_line_q [DEPTH], ent_line_d [DEPTH];
  logic [PW-1:0]   ent_col_q  [DEPTH], ent_col_d  [DEPTH];
  logic [7:0]      ent_len_q  [DEPTH], ent_len_d  [DEPTH];
  logic [7:0]      ent_bad_q  [DEPTH], ent_bad_d  [DEPTH];
  logic            ent_last_q [DEPTH], ent_last_d [DEPTH];

  assign in_ready_o = (cnt_q <= 3'd1);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop        = out_valid_o && out_ready_i;

  csl_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .is_end_i    (is_end_i),
    .res_n_o     (res_n),
    .res_kind_o  (res_kind),
    .res_line_o  (res_line),
    .res_column_o(res_column),
    .res_length_o(res_length),
    .res_bad_o   (res_bad)
  );

  assign push_n   = accept ? res_n : 2'd0;
  assign cnt_kept = cnt_q - {2'b0, pop};
  assign cnt_d    = cnt_kept + {1'b0, push_n};

  // Shift out the head on a pop, append new tokens behind what is kept
  always_comb begin
    logic [2:0] src;
    logic [2:0] j;
    for (int i = 0; i < DEPTH; i++) begin
      src = 3'(i) + {2'b0, pop};
      j   = 3'(i) - cnt_kept;
      ent_kind_d[i] = ent_kind_q[i];
      ent_line_d[i] = ent_line_q[i];
      ent_col_d[i]  = ent_col_q[i];
      ent_len_d[i]  = ent_len_q[i];
      ent_bad_d[i]  = ent_bad_q[i];
      ent_last_d[i] = ent_last_q[i];
      if (src < cnt_q) begin
        ent_kind_d[i] = ent_kind_q[src[1:0]];
        ent_line_d[i] = ent_line_q[src[1:0]];
        ent_col_d[i]  = ent_col_q[src[1:0]];
        ent_len_d[i]  = ent_len_q[src[1:0]];
        ent_bad_d[i]  = ent_bad_q[src[1:0]];
        ent_last_d[i] = ent_last_q[src[1:0]];
      end else if (3'(i) >= cnt_kept && j < {1'b0, push_n}) begin
        ent_kind_d[i] = res_kind[j[1:0]];
        ent_line_d[i] = res_line[j[1:0]];
        ent_col_d[i]  = res_column[j[1:0]];
        ent_len_d[i]  = res_length[j[1:0]];
        ent_bad_d[i]  = res_bad[j[1:0]];
        ent_last_d[i] = (j == {1'b0, push_n} - 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_kind_q <= ent_kind_d;
    ent_line_q <= ent_line_d;
    ent_col_q  <= ent_col_d;
    ent_len_q  <= ent_len_d;
    ent_bad_q  <= ent_bad_d;
    ent_last_q <= ent_last_d;
  end

  assign token_kind_o   = ent_kind_q[0];
  assign token_line_o   = ent_line_q[0];
  assign token_column_o = ent_col_q[0];
  assign token_length_o = ent_len_q[0];
  assign bad_char_o     = ent_bad_q[0];
  assign last_of_run_o  = ent_last_q[0];

endmodule

`default_nettype wire

### hw/rtl/csl_core.sv
// Lexer state registers and the single-pass logic that turns one byte into up to three tokens.
`default_nettype none

module csl_core
  import csl_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 255,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [7:0]               char_code_i,
  input  wire logic                     is_end_i,
  output logic      [1:0]               res_n_o,
  output logic      [5:0]               res_kind_o   [3],
  output logic      [POSITION_BITS-1:0] res_line_o   [3],
  output logic      [POSITION_BITS-1:0] res_column_o [3],
  output logic      [7:0]               res_length_o [3],
  output logic      [7:0]               res_bad_o    [3]
);

  localparam int RW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PW = POSITION_BITS;

  mode_e           mode_q, mode_d;
  logic [7:0]      kw_q, kw_d;
  logic [PW-1:0]   line_q, line_d, col_q, col_d;
  logic [PW-1:0]   scol_q, scol_d, sline_q, sline_d;
  logic [RW-1:0]   run_q, run_d;
  logic            ended_q, ended_d;

  logic [PW-1:0]   line_inc, col_inc;
  logic [RW-1:0]   run_inc;
  logic [7:0]      run_sat, run_inc_sat;
  kind_e           ident_kind;

  logic            do_flush, do_idle;
  logic            tail_v;
  kind_e           tail_kind;
  logic [PW-1:0]   tail_line, tail_col;
  logic [7:0]      tail_len, tail_bad;

  logic [1:0]      fl_n, fl_n_eff;
  kind_e           fl_kind [2];
  logic [7:0]      fl_len;

  function automatic logic [7:0] kw_step(input logic [7:0] kw, input logic [RW-1:0] run,
                                         input logic [7:0] c);
    logic [7:0] res;
    res = kw;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(32'(run) < 32'(KW_LEN[k]) && KW_TEXT[k][run[2:0]] == c)) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] len_sat(input logic [RW-1:0] run);
    logic [31:0] ext;
    ext = 32'(run);
    return (ext > 32'd255) ? 8'hFF : ext[7:0];
  endfunction

  assign line_inc    = (line_q == '1) ? line_q : line_q + PW'(1);
  assign col_inc     = (col_q == '1) ? col_q : col_q + PW'(1);
  assign run_inc     = (run_q < RW'(MAX_TOKEN_LEN)) ? run_q + RW'(1) : run_q;
  assign run_sat     = len_sat(run_q);
  assign run_inc_sat = len_sat(run_inc);

  always_comb begin
    ident_kind = TK_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_q[k] && 32'(run_q) == 32'(KW_LEN[k])) begin
        ident_kind = kind_e'(6'(TK_KW_INT) + 6'(k));
      end
    end
  end

  // Tokens owed by the pending run when it is cut short
  always_comb begin
    fl_n       = 2'd0;
    fl_kind[0] = TK_EOF;
    fl_kind[1] = TK_EOF;
    fl_len     = run_sat;
    case (mode_q)
      M_IDLE: ;
      M_NUM: begin
        fl_n       = 2'd1;
        fl_kind[0] = TK_INT_LIT;
      end
      M_IDENT: begin
        fl_n       = 2'd1;
        fl_kind[0] = ident_kind;
      end
      M_STR, M_ESC: begin
        fl_n       = 2'd2;
        fl_kind[0] = TK_UNCLOSED;
        fl_kind[1] = TK_STRING;
      end
      default: begin
        fl_n       = 2'd1;
        fl_kind[0] = op_single(mode_q);
        fl_len     = 8'd1;
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    kw_d      = kw_q;
    line_d    = line_q;
    col_d     = col_q;
    scol_d    = scol_q;
    sline_d   = sline_q;
    run_d     = run_q;
    ended_d   = ended_q;
    do_flush  = 1'b0;
    do_idle   = 1'b0;
    tail_v    = 1'b0;
    tail_kind = TK_EOF;
    tail_line = line_q;
    tail_col  = col_q;
    tail_len  = 8'd0;
    tail_bad  = 8'd0;

    if (ended_q) begin
      tail_v = 1'b1;
    end else if (is_end_i) begin
      do_flush = 1'b1;
      col_d    = col_inc;
      tail_v   = 1'b1;
      tail_col = col_inc;
      ended_d  = 1'b1;
    end else begin
      case (mode_q)
        M_IDLE: do_idle = 1'b1;
        M_NUM: begin
          if (is_digit(char_code_i)) begin
            col_d = col_inc;
            run_d = run_inc;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(char_code_i) || is_digit(char_code_i)) begin
            kw_d  = kw_step(kw_q, run_q, char_code_i);
            col_d = col_inc;
            run_d = run_inc;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        M_STR: begin
          if (char_code_i == CH_NL) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end else begin
            col_d = col_inc;
            run_d = run_inc;
            if (char_code_i == CH_QUOTE) begin
              tail_v    = 1'b1;
              tail_kind = TK_STRING;
              tail_line = sline_q;
              tail_col  = scol_q;
              tail_len  = run_inc_sat;
              mode_d    = M_IDLE;
              run_d     = '0;
            end else if (char_code_i == CH_BSLASH) begin
              mode_d = M_ESC;
            end
          end
        end
        M_ESC: begin
          run_d  = run_inc;
          mode_d = M_STR;
          if (char_code_i == CH_NL) begin
            line_d = line_inc;
            col_d  = '0;
          end else begin
            col_d = col_inc;
          end
        end
        default: begin
          if (char_code_i == op_second(mode_q)) begin
            col_d     = col_inc;
            tail_v    = 1'b1;
            tail_kind = op_pair(mode_q);
            tail_line = sline_q;
            tail_col  = scol_q;
            tail_len  = 8'd2;
            mode_d    = M_IDLE;
            run_d     = '0;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
      endcase
    end

    if (do_flush) begin
      mode_d = M_IDLE;
      kw_d   = '0;
      run_d  = '0;
    end

    // Byte seen with no token pending
    if (do_idle) begin
      mode_d = M_IDLE;
      if (char_code_i == CH_NL) begin
        line_d = line_inc;
        col_d  = '0;
      end else begin
        col_d = col_inc;
        if (!is_space(char_code_i)) begin
          if (is_digit(char_code_i) || is_alpha(char_code_i) || char_code_i == CH_QUOTE ||
              op_mode(char_code_i) != M_IDLE) begin
            scol_d  = col_inc;
            sline_d = line_q;
            run_d   = RW'(1);
            if (is_digit(char_code_i)) begin
              mode_d = M_NUM;
            end else if (is_alpha(char_code_i)) begin
              mode_d = M_IDENT;
              kw_d   = kw_step(8'hFF, '0, char_code_i);
            end else if (char_code_i == CH_QUOTE) begin
              mode_d = M_STR;
            end else begin
              mode_d = op_mode(char_code_i);
            end
          end else begin
            tail_v    = 1'b1;
            tail_kind = single_kind(char_code_i);
            tail_line = line_q;
            tail_col  = col_inc;
            tail_len  = 8'd1;
            if (single_kind(char_code_i) == TK_BAD_CHAR) begin
              tail_bad = char_code_i;
            end
          end
        end
      end
    end
  end

  assign fl_n_eff = do_flush ? fl_n : 2'd0;
  assign res_n_o  = fl_n_eff + {1'b0, tail_v};

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      res_kind_o[s]   = TK_EOF;
      res_line_o[s]   = '0;
      res_column_o[s] = '0;
      res_length_o[s] = '0;
      res_bad_o[s]    = '0;
      if (2'(s) < fl_n_eff) begin
        res_kind_o[s]   = fl_kind[s[0]];
        res_line_o[s]   = sline_q;
        res_column_o[s] = scol_q;
        res_length_o[s] = fl_len;
      end else if (tail_v && 2'(s) == fl_n_eff) begin
        res_kind_o[s]   = tail_kind;
        res_line_o[s]   = tail_line;
        res_column_o[s] = tail_col;
        res_length_o[s] = tail_len;
        res_bad_o[s]    = tail_bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      kw_q    <= '0;
      line_q  <= PW'(1);
      col_q   <= '0;
      scol_q  <= '0;
      sline_q <= PW'(1);
      run_q   <= '0;
      ended_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      line_q  <= line_d;
      col_q   <= col_d;
      scol_q  <= scol_d;
      sline_q <= sline_d;
      run_q   <= run_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire
